// ===== rtl/tksi_pkg.sv =====
// Top-K sorted insert: shared request/result types, field widths and the
// per-cell control struct. No dependencies.
package tksi_pkg;

    localparam int SCORE_W = 32;
    localparam int TAG_W   = 16;
    localparam int RANK_W  = 4;
    localparam int COUNT_W = 5;
    localparam int CFG_W   = 5;

    localparam logic [CFG_W-1:0] MAX_KEPT_RESET = 5'd4;

    // One incoming request
    typedef struct packed {
        logic                      start_new;
        logic signed [SCORE_W-1:0] improvement;
        logic        [TAG_W-1:0]   split_tag;
    } req_t;

    // One result
    typedef struct packed {
        logic               accepted;
        logic [RANK_W-1:0]  rank;
        logic [COUNT_W-1:0] list_count;
        logic               evicted;
        logic [TAG_W-1:0]   evicted_tag;
    } res_t;

    // Control that the top level hands to each cell
    typedef struct packed {
        logic load;       // a request is taken this cycle and may touch this cell
        logic force_new;  // start of a new list: take the request unconditionally
        logic in_list;    // cell holds a live entry
        logic append;     // request goes to the end of the list, at this cell
    } cell_ctrl_t;

endpackage

// ===== rtl/top_k_sorted_insert.sv =====
// Top level of the top-K sorted insert: a row of tksi_cell slots, the entry
// count, the capacity register and the result register. Depends on tksi_pkg.
//
// Keeps up to max_kept entries sorted by descending signed score; ties keep
// arrival order. busy is always low, so a request is taken in every cycle with
// start high, and its result appears with result_valid in the next cycle,
// for one cycle; results come in request order, one per request. This is
// possible because every cell compares the request against its own
// entry and shifts from its neighbor in the cycle the request is taken, while
// OR trees across the row form the rank and pick the tag of the last entry.
// The result port cannot be stalled. Write max_kept only while no request is
// in flight; values outside 1 .. MAX_ENTRIES are saturated into that range.
module top_k_sorted_insert #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  tksi_pkg::req_t               request,
    input  logic                         max_kept_we,
    input  logic [tksi_pkg::CFG_W-1:0]   max_kept_data,
    output logic                         result_valid,
    output tksi_pkg::res_t               result
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CMP_W = (CNT_W > tksi_pkg::CFG_W) ? CNT_W : tksi_pkg::CFG_W;

    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [tksi_pkg::CFG_W-1:0] max_kept_reg;
    tksi_pkg::res_t            result_reg, result_next;
    logic                      result_valid_reg;

    logic                      fire;
    logic [CMP_W-1:0]          kept_ext;
    logic [CNT_W-1:0]          cap;
    logic                      full;
    logic                      any_gt;
    logic [IDX_W-1:0]          pos;
    logic [tksi_pkg::TAG_W-1:0] last_tag;
    logic [CNT_W-1:0]          rank_wide;

    tksi_pkg::cell_ctrl_t                   ctrl  [MAX_ENTRIES];
    logic                                   gt    [MAX_ENTRIES];
    logic signed [tksi_pkg::SCORE_W-1:0]    score [MAX_ENTRIES];
    logic        [tksi_pkg::TAG_W-1:0]      tag   [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]                 gt_vec;

    assign busy = 1'b0;
    assign fire = start && !busy;

    // capacity, saturated into 1 .. MAX_ENTRIES
    assign kept_ext = CMP_W'(max_kept_reg);
    always_comb
    begin
        priority if (kept_ext == '0)
            cap = CNT_W'(1);
        else if (kept_ext > CMP_W'(MAX_ENTRIES))
            cap = CNT_W'(MAX_ENTRIES);
        else
            cap = CNT_W'(kept_ext);
    end
    assign full = (cnt_reg >= cap);

    // row of cells
    genvar gi;
    generate
        for (gi = 0; gi < MAX_ENTRIES; gi++)
        begin : g_cell
            logic                                left_gt;
            logic signed [tksi_pkg::SCORE_W-1:0] left_score;
            logic        [tksi_pkg::TAG_W-1:0]   left_tag;

            if (gi == 0)
            begin : g_head
                assign left_gt    = 1'b0;
                assign left_score = '0;
                assign left_tag   = '0;
            end
            else
            begin : g_body
                assign left_gt    = gt[gi-1];
                assign left_score = score[gi-1];
                assign left_tag   = tag[gi-1];
            end

            assign ctrl[gi].load      = fire && (!request.start_new || (gi == 0));
            assign ctrl[gi].force_new = request.start_new;
            assign ctrl[gi].in_list   = (CNT_W'(gi) < cnt_reg);
            assign ctrl[gi].append    = (CNT_W'(gi) == cnt_reg) && !any_gt && !full;
            assign gt_vec[gi]         = gt[gi];

            tksi_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl[gi]),
                .new_score  (request.improvement),
                .new_tag    (request.split_tag),
                .left_gt    (left_gt),
                .left_score (left_score),
                .left_tag   (left_tag),
                .gt         (gt[gi]),
                .score      (score[gi]),
                .tag        (tag[gi])
            );
        end
    endgenerate

    assign any_gt = |gt_vec;

    // first beaten slot and tag of the last live entry
    always_comb
    begin
        pos      = '0;
        last_tag = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (gt[i] && ((i == 0) || !gt[(i == 0) ? 0 : i - 1]))
                pos = pos | IDX_W'(i);
            if (CNT_W'(i + 1) == cnt_reg)
                last_tag = last_tag | tag[i];
        end
    end

    assign rank_wide = any_gt ? CNT_W'(pos) : cnt_reg;

    // result and new count
    always_comb
    begin
        result_next = '0;
        cnt_next    = cnt_reg;
        priority if (request.start_new)
        begin
            result_next.accepted = 1'b1;
            cnt_next             = CNT_W'(1);
        end
        else if (full)
        begin
            result_next.accepted = any_gt;
            result_next.evicted  = any_gt;
            if (any_gt)
            begin
                result_next.rank        = tksi_pkg::RANK_W'(pos);
                result_next.evicted_tag = last_tag;
            end
        end
        else
        begin
            result_next.accepted = 1'b1;
            result_next.rank     = tksi_pkg::RANK_W'(rank_wide);
            cnt_next             = cnt_reg + CNT_W'(1);
        end
        result_next.list_count = tksi_pkg::COUNT_W'(cnt_next);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg          <= '0;
            max_kept_reg     <= tksi_pkg::MAX_KEPT_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= fire;
            if (fire)
                cnt_reg <= cnt_next;
            if (max_kept_we)
                max_kept_reg <= max_kept_data;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (fire)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // count never exceeds the row
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count beyond row length");

    // every request yields a result in the next cycle
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> result_valid_reg)
        else $error("request without result");

    // an eviction is always an accepted insert
    a_evict_acc: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.evicted |-> result_reg.accepted)
        else $error("eviction without insert");

    // an eviction leaves the count unchanged
    a_evict_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.evicted |-> cnt_reg == $past(cnt_reg))
        else $error("count changed on eviction");

endmodule

// ===== rtl/tksi_cell.sv =====
// One list slot of the top-K sorted insert: holds a score and a tag, compares
// against the request and shifts from its left neighbor. Depends on tksi_pkg.
module tksi_cell (
    input  logic                                clk,
    input  tksi_pkg::cell_ctrl_t                ctrl,
    input  logic signed [tksi_pkg::SCORE_W-1:0] new_score,
    input  logic        [tksi_pkg::TAG_W-1:0]   new_tag,
    input  logic                                left_gt,
    input  logic signed [tksi_pkg::SCORE_W-1:0] left_score,
    input  logic        [tksi_pkg::TAG_W-1:0]   left_tag,
    output logic                                gt,
    output logic signed [tksi_pkg::SCORE_W-1:0] score,
    output logic        [tksi_pkg::TAG_W-1:0]   tag
);

    logic signed [tksi_pkg::SCORE_W-1:0] score_reg, score_next;
    logic        [tksi_pkg::TAG_W-1:0]   tag_reg, tag_next;

    // request beats the live entry held here
    assign gt = ctrl.in_list && (new_score > score_reg);

    // shift from the left, insert at the first beaten slot, or append
    always_comb
    begin
        score_next = score_reg;
        tag_next   = tag_reg;
        if (ctrl.load)
        begin
            priority if (ctrl.force_new)
            begin
                score_next = new_score;
                tag_next   = new_tag;
            end
            else if (left_gt)
            begin
                score_next = left_score;
                tag_next   = left_tag;
            end
            else if (gt || ctrl.append)
            begin
                score_next = new_score;
                tag_next   = new_tag;
            end
            else
            begin
                score_next = score_reg;
                tag_next   = tag_reg;
            end
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        score_reg <= score_next;
        tag_reg   <= tag_next;
    end

    assign score = score_reg;
    assign tag   = tag_reg;

endmodule

// ===== verif/tksi_checker.sv =====
// Checker for the top-K sorted insert: watches the request, result and max_kept
// channels, keeps its own copy of the sorted list and compares every result.
// Depends on tksi_pkg.
module tksi_checker #(
    parameter int DEPTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  tksi_pkg::req_t               request,
    input  logic                         max_kept_we,
    input  logic [tksi_pkg::CFG_W-1:0]   max_kept_data,
    input  logic                         result_valid,
    input  tksi_pkg::res_t               result,
    output int                           outstanding,
    output int                           error_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // Mirror of the list held by the block
    logic signed [tksi_pkg::SCORE_W-1:0] held_score [DEPTH];
    logic        [tksi_pkg::TAG_W-1:0]   held_tag   [DEPTH];
    int                                  held_count = 0;
    logic        [tksi_pkg::CFG_W-1:0]   kept_cap   = tksi_pkg::MAX_KEPT_RESET;

    tksi_pkg::res_t pending_results [$];
    int             errors = 0;

    assign error_count = errors;

    // Insert one candidate into the mirror list and form its result
    task automatic insert_candidate(input tksi_pkg::req_t rq, output tksi_pkg::res_t rs);
        int cap;
        int cnt;
        int pos;
        bit acc;
        bit ev;
        logic [tksi_pkg::TAG_W-1:0] ev_tag;
        cap    = kept_cap;
        cnt    = held_count;
        pos    = 0;
        acc    = 1'b0;
        ev     = 1'b0;
        ev_tag = '0;
        if (cap < 1)
            cap = 1;
        if (cap > DEPTH)
            cap = DEPTH;
        if (cnt > DEPTH)
            cnt = DEPTH;

        if (rq.start_new || cnt == 0)
        begin
            // new list, or empty list treated as one
            held_score[0] = rq.improvement;
            held_tag[0]   = rq.split_tag;
            cnt = 1;
            acc = 1'b1;
        end
        else
        begin
            // first entry that the candidate strictly beats
            pos = cnt;
            for (int i = 0; i < cnt; i++)
            begin
                if (rq.improvement > held_score[i])
                begin
                    pos = i;
                    break;
                end
            end
            if (cnt >= cap)
            begin
                // full (or over capacity): only a winner gets in, last one drops
                if (pos < cnt)
                begin
                    ev     = 1'b1;
                    ev_tag = held_tag[cnt-1];
                    for (int i = cnt - 1; i > pos; i--)
                    begin
                        held_score[i] = held_score[i-1];
                        held_tag[i]   = held_tag[i-1];
                    end
                    held_score[pos] = rq.improvement;
                    held_tag[pos]   = rq.split_tag;
                    acc = 1'b1;
                end
                else
                    pos = 0;
            end
            else
            begin
                for (int i = cnt; i > pos; i--)
                begin
                    held_score[i] = held_score[i-1];
                    held_tag[i]   = held_tag[i-1];
                end
                held_score[pos] = rq.improvement;
                held_tag[pos]   = rq.split_tag;
                cnt++;
                acc = 1'b1;
            end
        end
        held_count = cnt;

        rs.accepted    = acc;
        rs.rank        = pos[tksi_pkg::RANK_W-1:0];
        rs.list_count  = cnt[tksi_pkg::COUNT_W-1:0];
        rs.evicted     = ev;
        rs.evicted_tag = ev_tag;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // Compare results, then predict for a request taken at this edge
    always @(posedge clk or negedge rst_n)
    begin
        tksi_pkg::res_t want;
        tksi_pkg::res_t rs;
        if (!rst_n)
        begin
            held_count = 0;
            kept_cap   = tksi_pkg::MAX_KEPT_RESET;
            pending_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (result_valid)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result with no request outstanding");
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("accepted", 32'(want.accepted), 32'(result.accepted));
                    check_field("rank", 32'(want.rank), 32'(result.rank));
                    check_field("list_count", 32'(want.list_count),
                                32'(result.list_count));
                    check_field("evicted", 32'(want.evicted), 32'(result.evicted));
                    check_field("evicted_tag", 32'(want.evicted_tag),
                                32'(result.evicted_tag));
                end
            end
            if (start && !busy)
            begin
                insert_candidate(request, rs);
                pending_results.push_back(rs);
            end
            if (max_kept_we)
                kept_cap = max_kept_data;
            outstanding <= pending_results.size();
        end
    end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for the top-K sorted insert: clock, reset, request stimulus
// and max_kept settings, watchdog and verdict. Depends on tksi_pkg,
// top_k_sorted_insert and tksi_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES    = 16;
    localparam int IDLE_LIMIT = 2000;

    logic                       clk           = 1'b0;
    logic                       rst_n         = 1'b0;
    logic                       start         = 1'b0;
    logic                       busy;
    tksi_pkg::req_t             request       = '0;
    logic                       max_kept_we   = 1'b0;
    logic [tksi_pkg::CFG_W-1:0] max_kept_data = '0;
    logic                       result_valid;
    tksi_pkg::res_t             result;

    int   outstanding;
    int   error_count;
    logic busy_s      = 1'b0;
    int   idle_cycles = 0;
    int   burst_left  = 0;

    always #4 clk = ~clk;

    top_k_sorted_insert #(
        .MAX_ENTRIES(ENTRIES)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .max_kept_we  (max_kept_we),
        .max_kept_data(max_kept_data),
        .result_valid (result_valid),
        .result       (result)
    );

    tksi_checker #(
        .DEPTH(ENTRIES)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .max_kept_we  (max_kept_we),
        .max_kept_data(max_kept_data),
        .result_valid (result_valid),
        .result       (result),
        .outstanding  (outstanding),
        .error_count  (error_count)
    );

    // busy as it stands at the coming rising edge
    always @(negedge clk)
        busy_s <= busy;

    // Watchdog: too long without a request or result moving
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid)
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb_top: errors");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic tksi_pkg::req_t make_req(bit s, logic [31:0] sc, logic [15:0] tg);
        tksi_pkg::req_t r;
        r.start_new   = s;
        r.improvement = sc;
        r.split_tag   = tg;
        return r;
    endfunction

    // A small pool of scores so ties happen, plus extremes and noise
    function automatic tksi_pkg::req_t rand_req();
        int          pick;
        logic [31:0] sc;
        pick = $urandom_range(0, 9);
        unique case (pick)
            0: sc = 32'h7FFF_FFFF;
            1: sc = 32'h8000_0000;
            2, 3, 4, 5: sc = ($urandom_range(0, 7) - 4) * 32'h0001_0000;
            default: sc = $urandom();
        endcase
        return make_req($urandom_range(0, 49) == 0, sc, 16'($urandom_range(0, 65535)));
    endfunction

    // Present one request; start stays high when hold is set
    task automatic send_req(input tksi_pkg::req_t item, input bit hold);
        start   <= 1'b1;
        request <= item;
        do
            @(posedge clk);
        while (busy_s);
        if (!hold)
            start <= 1'b0;
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_max_kept(input logic [tksi_pkg::CFG_W-1:0] v);
        wait_drained();
        max_kept_we   <= 1'b1;
        max_kept_data <= v;
        @(posedge clk);
        max_kept_we   <= 1'b0;
    endtask

    task automatic send_back_to_back(input tksi_pkg::req_t items[$]);
        foreach (items[k])
            send_req(items[k], k < items.size() - 1);
    endtask

    // Random requests in bursts with gaps, now and then a full drain
    task automatic run_random(input int n);
        bit hold;
        burst_left = 0;
        for (int k = 0; k < n; k++)
        begin
            if (burst_left == 0)
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 8);
            burst_left--;
            hold = (k < n - 1) && (burst_left > 0);
            send_req(rand_req(), hold);
            if (!hold && k < n - 1)
            begin
                if ($urandom_range(0, 9) == 0)
                    wait_drained();
                else
                    repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    endtask

    initial
    begin
        tksi_pkg::req_t items[$];
        logic [tksi_pkg::CFG_W-1:0] caps[$];

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed at the reset capacity of four: empty list without start_new,
        // ties, extremes, rejection when full, eviction, start of a new list
        items = {
            make_req(1'b0, 32'h0001_0000, 16'h0001),
            make_req(1'b0, 32'h0001_0000, 16'h0002),
            make_req(1'b0, 32'h7FFF_FFFF, 16'hFFFF),
            make_req(1'b0, 32'h8000_0000, 16'h0003),
            make_req(1'b0, 32'h8000_0000, 16'h0004),
            make_req(1'b0, 32'h0000_0000, 16'h0005),
            make_req(1'b0, 32'h0002_0000, 16'h0006),
            make_req(1'b1, 32'hFFFF_FFFF, 16'hAAAA),
            make_req(1'b0, 32'hFFFF_FFFE, 16'h5555)
        };
        send_back_to_back(items);

        // Capacity lowered below the held count: list counts as full
        write_max_kept(5'd1);
        items = {
            make_req(1'b0, 32'h0000_0001, 16'h1234),
            make_req(1'b0, 32'h8000_0000, 16'h4321)
        };
        send_back_to_back(items);

        // Zero saturates to one
        write_max_kept(5'd0);
        items = {make_req(1'b0, 32'h7FFF_FFFF, 16'h00FF)};
        send_back_to_back(items);

        // Above the depth saturates to the depth
        write_max_kept(5'd31);
        items = {
            make_req(1'b0, 32'h8000_0000, 16'hFF00),
            make_req(1'b0, 32'h8000_0000, 16'h0F0F),
            make_req(1'b1, 32'h0000_0000, 16'h0000)
        };
        send_back_to_back(items);

        // Random phases over several capacities, lowering included
        caps = {5'd16, 5'd5, 5'd1, 5'd16, 5'd3, 5'd31, 5'd0, 5'd2,
                5'($urandom_range(0, 31)), 5'd4};
        foreach (caps[p])
        begin
            write_max_kept(caps[p]);
            run_random(120);
        end

        // Drain and verdict
        wait_drained();
        repeat (4) @(posedge clk);
        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tksi_pkg.sv
rtl/tksi_cell.sv
rtl/top_k_sorted_insert.sv
verif/tksi_checker.sv
verif/tb_top.sv
